/* hw/rtl/swpr_pkg.sv */
// shared types, constants and codes of the stop-and-wait packet receiver
`timescale 1ns / 1ps

package swpr_pkg;

   localparam int SEQ_W       = 16;
   localparam int LEN_W       = 13;
   localparam int BYTE_W      = 8;
   localparam int SUM_W       = 16;
   localparam int MAX_PAYLOAD = 4096;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SEQ_W-1:0] SEQ_MAX = 16'hFFFF;

   // input command codes
   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_BYTE   = 1'b1;

   // result kinds
   localparam logic KIND_ECHO    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // verdict codes
   localparam logic [1:0] VERDICT_BAD_SUM = 2'd0;
   localparam logic [1:0] VERDICT_SYN     = 2'd1;
   localparam logic [1:0] VERDICT_SEQ_ERR = 2'd2;
   localparam logic [1:0] VERDICT_ACCEPT  = 2'd3;

   // classified operations handed from front to back
   typedef enum logic [1:0] {
      OP_OPEN  = 2'd0,
      OP_EMPTY = 2'd1,
      OP_BYTE  = 2'd2,
      OP_LAST  = 2'd3
   } op_type;

   typedef struct packed {
      logic              command;
      logic              flag_syn;
      logic              flag_ack;
      logic              flag_data;
      logic              flag_fin;
      logic [SEQ_W-1:0]  seq_in;
      logic [LEN_W-1:0]  payload_len;
      logic [SUM_W-1:0]  check_in;
      logic [BYTE_W-1:0] payload_byte;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] byte_out;
      logic [1:0]        verdict;
      logic              ack_needed;
      logic [SEQ_W-1:0]  ack_seq;
      logic              ack_fin;
      logic              done_res;
      logic [LEN_W-1:0]  deliver_len;
      logic [SEQ_W-1:0]  expected_out;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic              flag_syn;
      logic              flag_data;
      logic              flag_fin;
      logic [SEQ_W-1:0]  seq;
      logic [LEN_W-1:0]  len;
      logic [SUM_W-1:0]  check;
      logic [BYTE_W-1:0] data_byte;
   } cmd_type;

endpackage

/* hw/rtl/swpr_fifo.sv */
// small register queue with same-cycle push and pop
`timescale 1ns / 1ps

module swpr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FullCnt);
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/swpr_front.sv */
// front end: clamps header length, tracks packet position, classifies beats
`timescale 1ns / 1ps

module swpr_front #(
   parameter int MAX_PAYLOAD = swpr_pkg::MAX_PAYLOAD
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  swpr_pkg::req_type req,
   output logic              cmd_push,
   output swpr_pkg::cmd_type cmd
);

   localparam int FullW = $clog2(MAX_PAYLOAD + 1);
   localparam int CntW  = (FullW < swpr_pkg::LEN_W) ? FullW : swpr_pkg::LEN_W;

   logic [CntW-1:0]            bytes_left_ff, bytes_left_in;
   logic [swpr_pkg::LEN_W-1:0] len_sat;
   logic                       too_long;

   // clamp oversized lengths to the configured maximum
   assign too_long = ({{(32 - swpr_pkg::LEN_W){1'b0}}, req.payload_len} > 32'(MAX_PAYLOAD));
   assign len_sat  = too_long ? swpr_pkg::LEN_W'(MAX_PAYLOAD) : req.payload_len;

   always_comb begin
      bytes_left_in = bytes_left_ff;
      cmd_push      = 1'b0;
      cmd.op        = swpr_pkg::OP_OPEN;
      cmd.flag_syn  = req.flag_syn;
      cmd.flag_data = req.flag_data;
      cmd.flag_fin  = req.flag_fin;
      cmd.seq       = req.seq_in;
      cmd.len       = len_sat;
      cmd.check     = req.check_in;
      cmd.data_byte = req.payload_byte;
      if (accept) begin
         if (req.command == swpr_pkg::CMD_HEADER) begin
            // a header mid-packet simply restarts the count
            bytes_left_in = CntW'(len_sat);
            cmd_push      = 1'b1;
            cmd.op        = (len_sat == '0) ? swpr_pkg::OP_EMPTY : swpr_pkg::OP_OPEN;
         end else if (bytes_left_ff != '0) begin
            // stray bytes with no open packet are dropped here
            bytes_left_in = bytes_left_ff - 1'b1;
            cmd_push      = 1'b1;
            cmd.op        = (bytes_left_ff == CntW'(1)) ? swpr_pkg::OP_LAST
                                                         : swpr_pkg::OP_BYTE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
      end else begin
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

/* hw/rtl/swpr_back.sv */
// back end: checksum accumulation, verdict and expected sequence tracking
`timescale 1ns / 1ps

module swpr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  swpr_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output swpr_pkg::rsp_type rsp
);

   logic [swpr_pkg::SEQ_W-1:0]  expected_ff, expected_in;
   logic [swpr_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [swpr_pkg::BYTE_W-1:0] hold_ff, hold_in;
   logic                        odd_ff, odd_in;
   logic                        syn_ff, syn_in;
   logic                        data_ff, data_in;
   logic                        fin_ff, fin_in;
   logic [swpr_pkg::SEQ_W-1:0]  seq_ff, seq_in;
   logic [swpr_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [swpr_pkg::SUM_W-1:0]  check_ff, check_in;

   logic [swpr_pkg::SUM_W-1:0]  pair_word;
   logic [swpr_pkg::SUM_W:0]    sum_raw;
   logic [swpr_pkg::SUM_W-1:0]  sum_new;
   logic [swpr_pkg::SUM_W-1:0]  final_sum;
   logic                        is_empty;
   logic                        v_syn, v_data, v_fin;
   logic [swpr_pkg::SEQ_W-1:0]  v_seq;
   logic [swpr_pkg::LEN_W-1:0]  v_len;
   logic [swpr_pkg::SUM_W-1:0]  v_check;
   logic                        seq_in_window;
   logic                        go;
   swpr_pkg::rsp_type           verdict_rsp;
   logic [swpr_pkg::SEQ_W-1:0]  verdict_expected;

   // ones' complement add of the current byte, paired with a held low byte
   assign pair_word = odd_ff ? {cmd.data_byte, hold_ff}
                             : {{(swpr_pkg::SUM_W - swpr_pkg::BYTE_W){1'b0}}, cmd.data_byte};
   assign sum_raw   = {1'b0, sum_ff} + {1'b0, pair_word};
   assign sum_new   = sum_raw[swpr_pkg::SUM_W-1:0]
                    + {{(swpr_pkg::SUM_W - 1){1'b0}}, sum_raw[swpr_pkg::SUM_W]};

   // an empty packet judges its own header fields against a zero sum
   assign is_empty  = (cmd.op == swpr_pkg::OP_EMPTY);
   assign final_sum = is_empty ? '0 : sum_new;
   assign v_syn     = is_empty ? cmd.flag_syn  : syn_ff;
   assign v_data    = is_empty ? cmd.flag_data : data_ff;
   assign v_fin     = is_empty ? cmd.flag_fin  : fin_ff;
   assign v_seq     = is_empty ? cmd.seq       : seq_ff;
   assign v_len     = is_empty ? cmd.len       : len_ff;
   assign v_check   = is_empty ? cmd.check     : check_ff;

   assign seq_in_window = (v_seq == expected_ff)
                       || ((expected_ff != '0) && (v_seq == expected_ff - 1'b1));

   always_comb begin
      verdict_rsp          = '0;
      verdict_expected     = expected_ff;
      verdict_rsp.kind     = swpr_pkg::KIND_VERDICT;
      verdict_rsp.byte_out = is_empty ? '0 : cmd.data_byte;
      if (~final_sum != v_check) begin
         verdict_rsp.verdict = swpr_pkg::VERDICT_BAD_SUM;
      end else if (v_syn) begin
         verdict_rsp.verdict = swpr_pkg::VERDICT_SYN;
         verdict_expected    = '0;
      end else if (!seq_in_window) begin
         verdict_rsp.verdict = swpr_pkg::VERDICT_SEQ_ERR;
      end else begin
         verdict_rsp.verdict    = swpr_pkg::VERDICT_ACCEPT;
         verdict_rsp.ack_needed = 1'b1;
         verdict_rsp.ack_seq    = v_seq;
         verdict_rsp.ack_fin    = v_fin;
         verdict_rsp.done_res   = v_fin;
         if (v_data) begin
            verdict_rsp.deliver_len = v_len;
            if ((v_seq == expected_ff) && (expected_ff != swpr_pkg::SEQ_MAX)) begin
               verdict_expected = expected_ff + 1'b1;
            end
         end
      end
      verdict_rsp.expected_out = verdict_expected;
   end

   // a header that opens a packet gives no result, so it never waits on the queue
   assign go = cmd_valid && (!rsp_full || (cmd.op == swpr_pkg::OP_OPEN));

   always_comb begin
      expected_in = expected_ff;
      sum_in      = sum_ff;
      hold_in     = hold_ff;
      odd_in      = odd_ff;
      syn_in      = syn_ff;
      data_in     = data_ff;
      fin_in      = fin_ff;
      seq_in      = seq_ff;
      len_in      = len_ff;
      check_in    = check_ff;
      cmd_pop     = go;
      rsp_push    = 1'b0;
      rsp         = '0;
      if (go) begin
         unique case (cmd.op)
            swpr_pkg::OP_OPEN, swpr_pkg::OP_EMPTY: begin
               syn_in   = cmd.flag_syn;
               data_in  = cmd.flag_data;
               fin_in   = cmd.flag_fin;
               seq_in   = cmd.seq;
               len_in   = cmd.len;
               check_in = cmd.check;
               sum_in   = '0;
               hold_in  = '0;
               odd_in   = 1'b0;
               if (is_empty) begin
                  rsp_push    = 1'b1;
                  rsp         = verdict_rsp;
                  expected_in = verdict_expected;
               end
            end
            swpr_pkg::OP_BYTE: begin
               if (odd_ff) begin
                  sum_in  = sum_new;
                  hold_in = '0;
                  odd_in  = 1'b0;
               end else begin
                  hold_in = cmd.data_byte;
                  odd_in  = 1'b1;
               end
               rsp_push     = 1'b1;
               rsp.kind     = swpr_pkg::KIND_ECHO;
               rsp.byte_out = cmd.data_byte;
            end
            swpr_pkg::OP_LAST: begin
               sum_in      = '0;
               hold_in     = '0;
               odd_in      = 1'b0;
               rsp_push    = 1'b1;
               rsp         = verdict_rsp;
               expected_in = verdict_expected;
            end
            default: begin
               rsp_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         sum_ff      <= '0;
         hold_ff     <= '0;
         odd_ff      <= 1'b0;
         syn_ff      <= 1'b0;
         data_ff     <= 1'b0;
         fin_ff      <= 1'b0;
         seq_ff      <= '0;
         len_ff      <= '0;
         check_ff    <= '0;
      end else begin
         expected_ff <= expected_in;
         sum_ff      <= sum_in;
         hold_ff     <= hold_in;
         odd_ff      <= odd_in;
         syn_ff      <= syn_in;
         data_ff     <= data_in;
         fin_ff      <= fin_in;
         seq_ff      <= seq_in;
         len_ff      <= len_in;
         check_ff    <= check_in;
      end
   end

endmodule

/* hw/rtl/stop_wait_packet_receiver.sv */
// top level of the stop-and-wait packet receiver
// path: an accepted beat is written into the command queue; the back end takes it
//   from there and writes its result into the result queue, where it can be popped
// throughput: one beat per cycle, header or payload, while the command queue has room
//   (a full result queue holds the back end); set by the single 16-bit ones' complement add in the back end
// reset: synchronous, active high; clears expected sequence, checksum and both queues
`timescale 1ns / 1ps

module stop_wait_packet_receiver #(
   parameter int MAX_PAYLOAD = swpr_pkg::MAX_PAYLOAD
) (
   input  logic              clock,
   input  logic              reset,
   // input queue side
   input  logic              push,
   output logic              full,
   input  swpr_pkg::req_type req_beat,
   // result queue side
   output logic              empty,
   input  logic              pop,
   output swpr_pkg::rsp_type rsp_beat
);

   localparam int CmdW = $bits(swpr_pkg::cmd_type);
   localparam int RspW = $bits(swpr_pkg::rsp_type);

   logic              accept;
   logic              cmd_push;
   swpr_pkg::cmd_type cmd_wr;
   logic [CmdW-1:0]   cmd_rd_bits;
   swpr_pkg::cmd_type cmd_rd;
   logic              cmd_empty;
   logic              cmd_pop;
   logic              rsp_push;
   swpr_pkg::rsp_type rsp_wr;
   logic              rsp_full;
   logic [RspW-1:0]   rsp_rd_bits;

   // a beat is taken whenever the command queue has room
   assign accept = push && !full;

   // front: length clamp, packet position, stray byte filter
   swpr_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_beat),
      .cmd_push(cmd_push),
      .cmd     (cmd_wr)
   );

   // decoupling queue between classification and execution
   swpr_fifo #(
      .WIDTH(CmdW),
      .DEPTH(swpr_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(cmd_wr),
      .full     (full),
      .pop      (cmd_pop),
      .pop_data (cmd_rd_bits),
      .empty    (cmd_empty)
   );

   assign cmd_rd = swpr_pkg::cmd_type'(cmd_rd_bits);

   // back: checksum, verdict, expected sequence
   swpr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(!cmd_empty),
      .cmd      (cmd_rd),
      .cmd_pop  (cmd_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp      (rsp_wr)
   );

   // result queue, lets the back keep going while a result waits to be popped
   swpr_fifo #(
      .WIDTH(RspW),
      .DEPTH(swpr_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_data(rsp_wr),
      .full     (rsp_full),
      .pop      (pop),
      .pop_data (rsp_rd_bits),
      .empty    (empty)
   );

   assign rsp_beat = swpr_pkg::rsp_type'(rsp_rd_bits);

endmodule
